[design/adp_pkg.sv]
`timescale 1ns / 1ps

package adp_pkg;

	localparam int FrameHalves = 82 / 2;
	localparam int CntW = $clog2(FrameHalves);
	localparam int QuarterMs = 1000 / 4;
	localparam logic [31:0] TrigDelayMs = 32'd1000;
	localparam logic [5:0] ValidSecondsRst = 6'd62;
	localparam int CfgDataW = 64;

	// item kinds
	localparam logic [1:0] MODE_TICK     = 2'd0;
	localparam logic [1:0] MODE_DISCOVER = 2'd1;
	localparam logic [1:0] MODE_GM_UPD   = 2'd2;
	localparam logic [1:0] MODE_TRIGGER  = 2'd3;

	typedef enum logic [2:0] {
		CFG_ENTITY_ID  = 3'd0,
		CFG_MODEL_ID   = 3'd1,
		CFG_ENT_CAPS   = 3'd2,
		CFG_CTRL_CAPS  = 3'd3,
		CFG_VALID_SECS = 3'd4,
		CFG_STREAM     = 3'd5,
		CFG_SRC_MAC    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [63:0] id_value;
	} in_word_t;

	typedef struct packed {
		logic [15:0] frame_half;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic [63:0] own_entity_id;
		logic [63:0] model_id;
		logic [31:0] entity_caps;
		logic [31:0] controller_caps;
		logic [5:0]  valid_seconds;
		logic [63:0] stream_info;
		logic [47:0] source_mac;
	} cfg_t;

	// state captured for one frame at send time
	typedef struct packed {
		logic [31:0] avail_index;
		logic [63:0] grandmaster_id;
	} send_req_t;

endpackage

[design/adp_entity_advertiser.sv]
`timescale 1ns / 1ps

// availability advertiser for one AVDECC entity. Input words are ticks,
// parsed discover targets, grandmaster id updates and send triggers; a tick
// sends a frame when a quarter of the valid time has passed since the last
// send or a trigger has been pending for at least 1000 ms. A frame leaves as
// 41 big-endian halfwords, one per cycle unless the output stalls, the last
// one flagged. Input words are taken one per cycle, unless a sending tick is
// held, through a one-word input stage; a word that does not send leaves that
// stage in the next cycle. A tick that sends waits in the input stage only
// while the previous frame is still being shifted out, and the words behind
// it wait with it, so back-to-back sends are limited by the halfword
// serializer: a new frame starts only once the previous one's last halfword
// is in the output register. Output is through a registered word with
// valid/ready. Configuration is written through cfg_we/cfg_index/cfg_data,
// by the user only while no frame is in flight; the block does not enforce it.

module adp_entity_advertiser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  adp_pkg::in_word_t              in_word,
	output logic                           out_valid,
	input  logic                           out_ready,
	output adp_pkg::out_word_t             out_word,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [adp_pkg::CfgDataW-1:0]   cfg_data
);
	import adp_pkg::*;

	cfg_t      cfg_q;
	send_req_t send_req;
	logic      send_valid;
	logic      send_ready;

	// configuration registers, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_entity_id   <= '0;
			cfg_q.model_id        <= '0;
			cfg_q.entity_caps     <= '0;
			cfg_q.controller_caps <= '0;
			cfg_q.valid_seconds   <= ValidSecondsRst;
			cfg_q.stream_info     <= '0;
			cfg_q.source_mac      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENTITY_ID:  cfg_q.own_entity_id   <= cfg_data;
				CFG_MODEL_ID:   cfg_q.model_id        <= cfg_data;
				CFG_ENT_CAPS:   cfg_q.entity_caps     <= cfg_data[31:0];
				CFG_CTRL_CAPS:  cfg_q.controller_caps <= cfg_data[31:0];
				CFG_VALID_SECS: cfg_q.valid_seconds   <= cfg_data[5:0];
				CFG_STREAM:     cfg_q.stream_info     <= cfg_data;
				CFG_SRC_MAC:    cfg_q.source_mac      <= cfg_data[47:0];
				default: begin
				end
			endcase
		end
	end

	// input stage, timers and advertise state
	adp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_word    (in_word),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cfg        (cfg_q),
		.send_req   (send_req),
		.send_valid (send_valid),
		.send_ready (send_ready)
	);

	// frame builder and halfword serializer with output register
	adp_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.send_req   (send_req),
		.send_valid (send_valid),
		.send_ready (send_ready),
		.out_word   (out_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule

[design/adp_ctrl.sv]
`timescale 1ns / 1ps

module adp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  adp_pkg::in_word_t in_word,
	input  logic              in_valid,
	output logic              in_ready,
	input  adp_pkg::cfg_t     cfg,
	output adp_pkg::send_req_t send_req,
	output logic              send_valid,
	input  logic              send_ready
);
	import adp_pkg::*;

	in_word_t    word_s1;
	logic        valid_s1;
	logic [31:0] last_send_q;
	logic [31:0] trig_ms_q;
	logic        trig_pending_q;
	logic [31:0] avail_index_q;
	logic [63:0] gm_id_q;

	logic [13:0] qp;
	logic        timed;
	logic        trig;
	logic        is_tick;
	logic        done_s1;
	logic        disc_hit;

	assign qp       = 14'(cfg.valid_seconds) * 14'(QuarterMs);
	assign timed    = (word_s1.now_ms - last_send_q) >= {18'd0, qp};
	assign trig     = trig_pending_q && ((word_s1.now_ms - trig_ms_q) >= TrigDelayMs);
	assign is_tick  = word_s1.mode == MODE_TICK;
	assign disc_hit = (word_s1.id_value == cfg.own_entity_id) ||
	                  (word_s1.id_value == '1) || (word_s1.id_value == '0);

	assign send_valid = valid_s1 && is_tick && (timed || trig);
	assign done_s1    = !send_valid || send_ready;
	assign in_ready   = !valid_s1 || done_s1;

	assign send_req.avail_index    = avail_index_q;
	assign send_req.grandmaster_id = gm_id_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1 <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			last_send_q    <= '0;
			trig_ms_q      <= '0;
			trig_pending_q <= 1'b0;
			avail_index_q  <= '0;
			gm_id_q        <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && done_s1) begin
				unique case (word_s1.mode)
					MODE_TICK: begin
						if (send_valid) begin
							trig_pending_q <= 1'b0;
							last_send_q    <= word_s1.now_ms;
							avail_index_q  <= avail_index_q + 32'd1;
						end
					end
					MODE_DISCOVER: begin
						if (disc_hit) begin
							last_send_q <= last_send_q - {18'd0, qp};
						end
					end
					MODE_GM_UPD: begin
						if (word_s1.id_value != gm_id_q) begin
							gm_id_q <= word_s1.id_value;
							if (!trig_pending_q) begin
								trig_pending_q <= 1'b1;
								trig_ms_q      <= word_s1.now_ms;
							end
						end
					end
					MODE_TRIGGER: begin
						if (!trig_pending_q) begin
							trig_pending_q <= 1'b1;
							trig_ms_q      <= word_s1.now_ms;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	a_send_clears_trig: assert property (@(posedge clk) disable iff (!arst_n)
		send_valid && send_ready |=> !trig_pending_q)
		else $error("pending trigger survived a send");

	a_send_bumps_index: assert property (@(posedge clk) disable iff (!arst_n)
		send_valid && send_ready |=> avail_index_q == $past(avail_index_q) + 32'd1)
		else $error("available index not advanced after send");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !done_s1 |=> valid_s1 && word_s1 == $past(word_s1))
		else $error("stalled item lost from stage one");

endmodule

[design/adp_frame.sv]
`timescale 1ns / 1ps

module adp_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  adp_pkg::cfg_t      cfg,
	input  adp_pkg::send_req_t send_req,
	input  logic               send_valid,
	output logic               send_ready,
	output adp_pkg::out_word_t out_word,
	output logic               out_valid,
	input  logic               out_ready
);
	import adp_pkg::*;

	localparam logic [CntW-1:0] LastIdx = CntW'(FrameHalves - 1);

	logic            busy_q;
	logic [CntW-1:0] cnt_q;
	send_req_t       snap_q;
	logic            out_valid_q;
	out_word_t       out_word_q;
	logic            advance;
	logic [15:0]     half;

	assign send_ready = !busy_q;
	assign advance    = busy_q && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;

	// halfword at position cnt_q of the available frame
	always_comb begin
		case (cnt_q)
			6'd0:  half = 16'h91E0;
			6'd1:  half = 16'hF001;
			6'd2:  half = 16'h0000;
			6'd3:  half = cfg.source_mac[47:32];
			6'd4:  half = cfg.source_mac[31:16];
			6'd5:  half = cfg.source_mac[15:0];
			6'd6:  half = 16'h22F0;
			6'd7:  half = 16'hFA00;
			6'd8:  half = {cfg.valid_seconds[5:1], 3'b000, 8'h38};
			6'd9:  half = cfg.own_entity_id[63:48];
			6'd10: half = cfg.own_entity_id[47:32];
			6'd11: half = cfg.own_entity_id[31:16];
			6'd12: half = cfg.own_entity_id[15:0];
			6'd13: half = cfg.model_id[63:48];
			6'd14: half = cfg.model_id[47:32];
			6'd15: half = cfg.model_id[31:16];
			6'd16: half = cfg.model_id[15:0];
			6'd17: half = cfg.entity_caps[31:16];
			6'd18: half = cfg.entity_caps[15:0];
			6'd19: half = cfg.stream_info[63:48];
			6'd20: half = cfg.stream_info[47:32];
			6'd21: half = cfg.stream_info[31:16];
			6'd22: half = cfg.stream_info[15:0];
			6'd23: half = cfg.controller_caps[31:16];
			6'd24: half = cfg.controller_caps[15:0];
			6'd25: half = snap_q.avail_index[31:16];
			6'd26: half = snap_q.avail_index[15:0];
			6'd27: half = snap_q.grandmaster_id[63:48];
			6'd28: half = snap_q.grandmaster_id[47:32];
			6'd29: half = snap_q.grandmaster_id[31:16];
			6'd30: half = snap_q.grandmaster_id[15:0];
			default: half = 16'h0000;
		endcase
	end

	always_ff @(posedge clk) begin
		if (send_valid && !busy_q) begin
			snap_q <= send_req;
		end
		if (advance) begin
			out_word_q.frame_half <= half;
			out_word_q.last       <= cnt_q == LastIdx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (send_valid && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				cnt_q       <= cnt_q + CntW'(1);
				if (cnt_q == LastIdx) begin
					busy_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q <= LastIdx)
		else $error("halfword counter ran past frame end");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt_q == LastIdx |=> !busy_q && out_word_q.last)
		else $error("frame did not close on its last word");

	a_no_last_mid: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cnt_q != LastIdx |=> busy_q && !out_word_q.last)
		else $error("last flag raised inside a frame");

endmodule
